>>> rtl/core/bfa_pkg.sv
// Types and constants shared by the allocator modules.
// No dependencies.
`timescale 1ns / 1ps

package bfa_pkg;

	// offset and size width of a table entry and of the beat fields
	localparam int OFF_W = 16;

	localparam logic [1:0] KIND_INIT  = 2'd0;
	localparam logic [1:0] KIND_ALLOC = 2'd1;
	localparam logic [1:0] KIND_FREE  = 2'd2;

	localparam logic [OFF_W-1:0] POOL_RESET = 16'd4096;

	typedef struct packed {
		logic [1:0]       kind;
		logic [OFF_W-1:0] request_size;
		logic [OFF_W-1:0] block_offset;
	} req_t;

	typedef struct packed {
		logic             ok;
		logic [OFF_W-1:0] payload_offset;
	} rsp_t;

	// one block: header offset, payload size, allocated mark
	typedef struct packed {
		logic [OFF_W-1:0] start;
		logic [OFF_W-1:0] size;
		logic             used;
	} entry_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_START,
		OP_INIT,
		OP_RD_IDX,
		OP_EVAL_ALLOC,
		OP_EVAL_FREE,
		OP_SET_J,
		OP_RD_J,
		OP_WR_J,
		OP_WR_HI,
		OP_WR_BEST,
		OP_RD_NEXT,
		OP_MERGE_NEXT,
		OP_RD_K,
		OP_WR_K,
		OP_DEC,
		OP_WR_CUR,
		OP_RD_PREV,
		OP_MERGE_PREV,
		OP_RESP
	} op_t;

	typedef enum logic [1:0] {
		RES_OK,
		RES_FAIL,
		RES_GRANT
	} res_t;

	typedef struct packed {
		op_t  op;
		res_t res;
	} cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       found;
		logic       idx_lt_cnt;
		logic       j_gt;
		logic       split;
		logic       k1_lt;
		logic       next_ok;
		logic       cur_nz;
		logic       rd_used;
		logic       match;
		logic       out_free;
	} sts_t;

endpackage

>>> rtl/core/best_fit_block_allocator.sv
// Top level of the best-fit block allocator: sequencer plus datapath.
// Depends on bfa_pkg, bfa_ctrl, bfa_dp (and through it bfa_ram).
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | bfa_pkg::req_t (kind, size, offset)
//   rsp     | out       | rsp_valid/rsp_ready  | bfa_pkg::rsp_t (ok, payload_offset)
//   cfg     | in        | cfg_valid/cfg_ready  | cfg_data = pool_size
//
// One item at a time. Each table access is a RAM read, then an evaluate or
// write step; an allocate scans the table, then shifts entries up for a
// split; a free searches for the block, then runs up to two merge shifts.
// Reset leaves no pool until an init beat; the table needs no clearing pass.
// A stalled rsp beat holds; the next req beat is taken and worked meanwhile.
`timescale 1ns / 1ps

module best_fit_block_allocator #(
	parameter int MAX_BLOCKS   = 64,
	parameter int HEADER_BYTES = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_ready,
	input  bfa_pkg::req_t             req,
	output logic                      rsp_valid,
	input  logic                      rsp_ready,
	output bfa_pkg::rsp_t             rsp,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [bfa_pkg::OFF_W-1:0] cfg_data
);

	bfa_pkg::cmd_t cmd;
	bfa_pkg::sts_t sts;

	bfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bfa_dp #(
		.MAX_BLOCKS   (MAX_BLOCKS),
		.HEADER_BYTES (HEADER_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

>>> rtl/core/bfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bfa_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, held when idle
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/core/bfa_ctrl.sv
// Sequencer of the allocator: scan, shift and merge steps, response hand-off.
// Depends on bfa_pkg.
`timescale 1ns / 1ps

module bfa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  bfa_pkg::sts_t sts,
	output bfa_pkg::cmd_t cmd
);

	typedef enum logic [21:0] {
		S_IDLE   = 22'h000001,
		S_DISP   = 22'h000002,
		S_ARD    = 22'h000004,
		S_AEV    = 22'h000008,
		S_IJ     = 22'h000010,
		S_ICHK   = 22'h000020,
		S_IWR    = 22'h000040,
		S_WHI    = 22'h000080,
		S_WBEST  = 22'h000100,
		S_FRD    = 22'h000200,
		S_FEV    = 22'h000400,
		S_FNXT   = 22'h000800,
		S_FNXE   = 22'h001000,
		S_RCHK   = 22'h002000,
		S_RWR    = 22'h004000,
		S_WCUR   = 22'h008000,
		S_FPRV   = 22'h010000,
		S_FPRE   = 22'h020000,
		S_ROK    = 22'h040000,
		S_RFAIL  = 22'h080000,
		S_RGRANT = 22'h100000,
		S_SPARE  = 22'h200000
	} state_t;

	state_t state_q, state_d;
	logic   phase_q, phase_d; // 0: removing successor, 1: removing merged block

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

	assign req_ready = (state_q == S_IDLE);

	// next state and datapath command
	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		cmd.op  = bfa_pkg::OP_NONE;
		cmd.res = bfa_pkg::RES_FAIL;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.op  = bfa_pkg::OP_START;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				case (sts.kind)
					bfa_pkg::KIND_INIT: begin
						cmd.op  = bfa_pkg::OP_INIT;
						state_d = S_ROK;
					end
					bfa_pkg::KIND_ALLOC: state_d = S_ARD;
					bfa_pkg::KIND_FREE:  state_d = S_FRD;
					default:             state_d = S_RFAIL;
				endcase
			end
			// best-fit scan: read an entry, then evaluate it
			S_ARD: begin
				if (sts.idx_lt_cnt) begin
					cmd.op  = bfa_pkg::OP_RD_IDX;
					state_d = S_AEV;
				end else if (!sts.found) begin
					state_d = S_RFAIL;
				end else if (sts.split) begin
					state_d = S_IJ;
				end else begin
					state_d = S_WBEST;
				end
			end
			S_AEV: begin
				cmd.op  = bfa_pkg::OP_EVAL_ALLOC;
				state_d = S_ARD;
			end
			// open a slot after the chosen block
			S_IJ: begin
				cmd.op  = bfa_pkg::OP_SET_J;
				state_d = S_ICHK;
			end
			S_ICHK: begin
				if (sts.j_gt) begin
					cmd.op  = bfa_pkg::OP_RD_J;
					state_d = S_IWR;
				end else begin
					state_d = S_WHI;
				end
			end
			S_IWR: begin
				cmd.op  = bfa_pkg::OP_WR_J;
				state_d = S_ICHK;
			end
			S_WHI: begin
				cmd.op  = bfa_pkg::OP_WR_HI;
				state_d = S_WBEST;
			end
			S_WBEST: begin
				cmd.op  = bfa_pkg::OP_WR_BEST;
				state_d = S_RGRANT;
			end
			// free: locate the block by payload offset
			S_FRD: begin
				if (sts.idx_lt_cnt) begin
					cmd.op  = bfa_pkg::OP_RD_IDX;
					state_d = S_FEV;
				end else begin
					state_d = S_RFAIL;
				end
			end
			S_FEV: begin
				cmd.op  = bfa_pkg::OP_EVAL_FREE;
				state_d = sts.match ? S_FNXT : S_FRD;
			end
			S_FNXT: begin
				if (sts.next_ok) begin
					cmd.op  = bfa_pkg::OP_RD_NEXT;
					state_d = S_FNXE;
				end else begin
					state_d = S_WCUR;
				end
			end
			S_FNXE: begin
				if (!sts.rd_used) begin
					cmd.op  = bfa_pkg::OP_MERGE_NEXT;
					phase_d = 1'b0;
					state_d = S_RCHK;
				end else begin
					state_d = S_WCUR;
				end
			end
			// close the gap left by a merged entry
			S_RCHK: begin
				if (sts.k1_lt) begin
					cmd.op  = bfa_pkg::OP_RD_K;
					state_d = S_RWR;
				end else begin
					cmd.op  = bfa_pkg::OP_DEC;
					state_d = phase_q ? S_ROK : S_WCUR;
				end
			end
			S_RWR: begin
				cmd.op  = bfa_pkg::OP_WR_K;
				state_d = S_RCHK;
			end
			S_WCUR: begin
				cmd.op  = bfa_pkg::OP_WR_CUR;
				state_d = S_FPRV;
			end
			S_FPRV: begin
				if (sts.cur_nz) begin
					cmd.op  = bfa_pkg::OP_RD_PREV;
					state_d = S_FPRE;
				end else begin
					state_d = S_ROK;
				end
			end
			S_FPRE: begin
				if (!sts.rd_used) begin
					cmd.op  = bfa_pkg::OP_MERGE_PREV;
					phase_d = 1'b1;
					state_d = S_RCHK;
				end else begin
					state_d = S_ROK;
				end
			end
			// response beats wait for a free output register
			S_ROK: begin
				if (sts.out_free) begin
					cmd.op  = bfa_pkg::OP_RESP;
					cmd.res = bfa_pkg::RES_OK;
					state_d = S_IDLE;
				end
			end
			S_RFAIL: begin
				if (sts.out_free) begin
					cmd.op  = bfa_pkg::OP_RESP;
					cmd.res = bfa_pkg::RES_FAIL;
					state_d = S_IDLE;
				end
			end
			S_RGRANT: begin
				if (sts.out_free) begin
					cmd.op  = bfa_pkg::OP_RESP;
					cmd.res = bfa_pkg::RES_GRANT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

>>> rtl/core/bfa_dp.sv
// Datapath of the allocator: block table RAM, scan registers, output register.
// Depends on bfa_pkg and bfa_ram.
`timescale 1ns / 1ps

module bfa_dp #(
	parameter int MAX_BLOCKS   = 64,
	parameter int HEADER_BYTES = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  bfa_pkg::req_t                   req,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bfa_pkg::OFF_W-1:0]       cfg_data,
	output logic                            rsp_valid,
	input  logic                            rsp_ready,
	output bfa_pkg::rsp_t                   rsp,
	input  bfa_pkg::cmd_t                   cmd,
	output bfa_pkg::sts_t                   sts
);

	localparam int OW = bfa_pkg::OFF_W;
	localparam int IW = $clog2(MAX_BLOCKS);
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam logic [OW-1:0] HDR  = OW'(HEADER_BYTES);
	localparam logic [CW-1:0] CMAX = CW'(MAX_BLOCKS);
	localparam logic [CW-1:0] ONE  = CW'(1);

	bfa_pkg::req_t   item_q;
	logic [OW-1:0]   pool_q;
	logic [CW-1:0]   count_q, idx_q, sel_q, j_q, k_q;
	logic            found_q;
	logic [OW-1:0]   diff_q, sel_start_q, sel_size_q;
	logic            rsp_valid_q;
	bfa_pkg::rsp_t   rsp_q;

	logic            we, re;
	logic [IW-1:0]   waddr, raddr;
	bfa_pkg::entry_t wdata, rd;
	logic [$bits(bfa_pkg::entry_t)-1:0] rd_raw;

	logic            fit, take;
	logic [OW-1:0]   diff_now;
	logic [OW:0]     hdr_end;
	logic            split;

	// neighbour indexes used for table addressing
	logic [CW-1:0]   j_dn, sel_up, sel_dn, k_up;

	bfa_ram #(
		.WIDTH ($bits(bfa_pkg::entry_t)),
		.DEPTH (MAX_BLOCKS)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rd_raw)
	);

	assign rd = bfa_pkg::entry_t'(rd_raw);

	assign j_dn   = j_q - ONE;
	assign sel_up = sel_q + ONE;
	assign sel_dn = sel_q - ONE;
	assign k_up   = k_q + ONE;

	// scan evaluation on the entry just read
	assign diff_now = rd.size - item_q.request_size;
	assign fit      = !rd.used && (rd.size >= item_q.request_size);
	assign take     = fit && (!found_q || (diff_now < diff_q));
	assign hdr_end  = {1'b0, rd.start} + {1'b0, HDR};
	assign split    = (diff_q > HDR) && (count_q < CMAX);

	// status to the sequencer
	always_comb begin
		sts.kind       = item_q.kind;
		sts.found      = found_q;
		sts.idx_lt_cnt = idx_q < count_q;
		sts.j_gt       = j_q > sel_up;
		sts.split      = split;
		sts.k1_lt      = k_up < count_q;
		sts.next_ok    = sel_up < count_q;
		sts.cur_nz     = sel_q != '0;
		sts.rd_used    = rd.used;
		sts.match      = hdr_end == {1'b0, item_q.block_offset};
		sts.out_free   = !rsp_valid_q || rsp_ready;
	end

	// table port steering
	always_comb begin
		we    = 1'b0;
		re    = 1'b0;
		waddr = '0;
		raddr = '0;
		wdata = rd;
		case (cmd.op)
			bfa_pkg::OP_INIT: begin
				we          = 1'b1;
				wdata.start = '0;
				wdata.size  = (pool_q > HDR) ? (pool_q - HDR) : '0;
				wdata.used  = 1'b0;
			end
			bfa_pkg::OP_RD_IDX: begin
				re    = 1'b1;
				raddr = idx_q[IW-1:0];
			end
			bfa_pkg::OP_RD_J: begin
				re    = 1'b1;
				raddr = j_dn[IW-1:0];
			end
			bfa_pkg::OP_WR_J: begin
				we    = 1'b1;
				waddr = j_q[IW-1:0];
			end
			bfa_pkg::OP_WR_HI: begin
				we          = 1'b1;
				waddr       = sel_up[IW-1:0];
				wdata.start = sel_start_q + HDR + item_q.request_size;
				wdata.size  = diff_q - HDR;
				wdata.used  = 1'b0;
			end
			bfa_pkg::OP_WR_BEST: begin
				we          = 1'b1;
				waddr       = sel_q[IW-1:0];
				wdata.start = sel_start_q;
				wdata.size  = split ? item_q.request_size : sel_size_q;
				wdata.used  = 1'b1;
			end
			bfa_pkg::OP_RD_NEXT: begin
				re    = 1'b1;
				raddr = sel_up[IW-1:0];
			end
			bfa_pkg::OP_RD_K: begin
				re    = 1'b1;
				raddr = k_up[IW-1:0];
			end
			bfa_pkg::OP_WR_K: begin
				we    = 1'b1;
				waddr = k_q[IW-1:0];
			end
			bfa_pkg::OP_WR_CUR: begin
				we          = 1'b1;
				waddr       = sel_q[IW-1:0];
				wdata.start = sel_start_q;
				wdata.size  = sel_size_q;
				wdata.used  = 1'b0;
			end
			bfa_pkg::OP_RD_PREV: begin
				re    = 1'b1;
				raddr = sel_dn[IW-1:0];
			end
			bfa_pkg::OP_MERGE_PREV: begin
				we         = 1'b1;
				waddr      = sel_dn[IW-1:0];
				wdata.size = rd.size + sel_size_q + HDR;
				wdata.used = 1'b0;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// control registers: pool size, block count, scan flag, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q      <= bfa_pkg::POOL_RESET;
			count_q     <= '0;
			found_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				pool_q <= cfg_data;
			end
			case (cmd.op)
				bfa_pkg::OP_START:      found_q <= 1'b0;
				bfa_pkg::OP_INIT:       count_q <= ONE;
				bfa_pkg::OP_EVAL_ALLOC: if (take) found_q <= 1'b1;
				bfa_pkg::OP_WR_BEST:    if (split) count_q <= count_q + ONE;
				bfa_pkg::OP_DEC:        count_q <= count_q - ONE;
				default: begin
				end
			endcase
			if (cmd.op == bfa_pkg::OP_RESP) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// working registers of the current item
	always_ff @(posedge clk) begin
		case (cmd.op)
			bfa_pkg::OP_START: begin
				item_q <= req;
				idx_q  <= '0;
			end
			bfa_pkg::OP_EVAL_ALLOC: begin
				idx_q <= idx_q + ONE;
				if (take) begin
					sel_q       <= idx_q;
					diff_q      <= diff_now;
					sel_start_q <= rd.start;
					sel_size_q  <= rd.size;
				end
			end
			bfa_pkg::OP_EVAL_FREE: begin
				idx_q       <= idx_q + ONE;
				sel_q       <= idx_q;
				sel_start_q <= rd.start;
				sel_size_q  <= rd.size;
			end
			bfa_pkg::OP_SET_J:      j_q <= count_q;
			bfa_pkg::OP_WR_J:       j_q <= j_q - ONE;
			bfa_pkg::OP_MERGE_NEXT: begin
				sel_size_q <= sel_size_q + rd.size + HDR;
				k_q        <= sel_up;
			end
			bfa_pkg::OP_WR_K:       k_q <= k_q + ONE;
			bfa_pkg::OP_MERGE_PREV: k_q <= sel_q;
			default: begin
			end
		endcase
		if (cmd.op == bfa_pkg::OP_RESP) begin
			rsp_q.ok             <= (cmd.res != bfa_pkg::RES_FAIL);
			rsp_q.payload_offset <= (cmd.res == bfa_pkg::RES_GRANT) ?
				(sel_start_q + HDR) : '0;
		end
	end

	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
